>>> src/swm_pkg.sv
// shared constants and types for the sliding window mean unit
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    // window length register
    localparam int             CFG_W            = 7;
    localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 7'd4;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_UPD   = 6'b000100,
        S_START = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    // handshake between sequencer and divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

>>> src/swm_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module swm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/swm_div.sv
// radix-2 restoring divider, signed sum scaled by 2^frac over an unsigned window length
`timescale 1ns / 1ps
`default_nettype none

module swm_div #(
    parameter int SUM_W     = 22,
    parameter int DIV_W     = 7,
    parameter int FRAC_BITS = 8,
    parameter int OUT_W     = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [SUM_W-1:0] i_sum,
    input  wire logic [DIV_W-1:0]        i_divisor,
    output swm_pkg::t_div_stat           o_stat,
    output logic      [OUT_W-1:0]        o_quotient
);

    import swm_pkg::*;

    localparam int DIVD_W = SUM_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] r_quo, n_quo;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy, r_done, r_neg;

    logic [SUM_W-1:0]  mag;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              q_bit;
    logic [OUT_W-1:0]  q_low;

    // magnitude of the sum, most negative value maps onto its unsigned twin
    assign mag = i_sum[SUM_W-1] ? (~i_sum + SUM_W'(1)) : i_sum;

    // one quotient bit a cycle
    assign trial = {r_rem, r_quo[DIVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign q_bit = (trial >= {1'b0, r_dvs});

    always_comb begin
        n_rem = q_bit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        n_quo = {r_quo[DIVD_W-2:0], q_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= DIVD_W'(mag) << FRAC_BITS;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_neg <= i_sum[SUM_W-1];
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    // truncation toward zero: negate the magnitude quotient for a negative sum
    assign q_low      = r_quo[OUT_W-1:0];
    assign o_quotient = r_neg ? (~q_low + OUT_W'(1)) : q_low;

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

>>> src/sliding_window_mean_unit.sv
// sliding window mean unit: ring of samples, running sum and shared serial divider
//   input channel  : i_valid / o_ready carry i_sample (signed) and i_new_array;
//                    a transfer happens when both are high at a rising edge
//   output channel : o_valid / i_ready carry o_window_mean, signed, FRAC_BITS
//                    fractional bits, mean of the last window_len samples
//                    truncated toward zero
//   configuration  : i_cfg_wr_en writes i_cfg_wr_data into window_len between
//                    samples; every write empties the window; zero acts as 1,
//                    values above WINDOW_MAX act as WINDOW_MAX
//   timing         : one sample at a time; a sample giving no mean passes through
//                    S_READ and S_UPD back to S_IDLE before the next ready; one
//                    giving a mean also passes S_START, S_DIV and S_OUT, paced by the
//                    restoring divider that makes one quotient bit a cycle; the
//                    mean is loaded into the output register in S_OUT, after the
//                    divider raises done and the sequencer leaves S_DIV
//   stall          : the finished mean sits in an output register, so the next
//                    sample is taken while it waits; a later mean holds in the
//                    sequencer until that register is free
//   reset          : i_rst_n, synchronous active low, empties the window and
//                    sets window_len to 4; the sample ring is not cleared
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_mean_unit #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = swm_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [swm_pkg::CFG_W-1:0]           i_cfg_wr_data,
    // sample input
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  wire logic                                i_new_array,
    // mean output
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [SAMPLE_BITS+FRAC_BITS-1:0]  o_window_mean
);

    import swm_pkg::*;

    localparam int OUT_W = SAMPLE_BITS + FRAC_BITS;
    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int MW    = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int CMP_W = (MW > CFG_W) ? MW : CFG_W;
    localparam int IDX_W = ((PTR_W > MW) ? PTR_W : MW) + 1;

    // control state
    t_state                   r_state;
    logic [CFG_W-1:0]         r_window_len;
    logic [MW-1:0]            r_fill;
    logic [PTR_W-1:0]         r_wp;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_out_valid;

    // payload
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [OUT_W-1:0]              r_mean;

    // effective window and ring addressing
    logic [CMP_W-1:0]         wl_ext;
    logic [MW-1:0]            eff_m;
    logic [IDX_W-1:0]         wp_x, m_x, old_x;
    logic [PTR_W-1:0]         old_idx;
    logic [PTR_W-1:0]         wp_next;
    logic [MW-1:0]            fill_next;
    logic                     window_full;

    logic [SAMPLE_BITS-1:0]   ram_rd_data;
    logic signed [SUM_W-1:0]  old_term;
    logic signed [SUM_W-1:0]  sum_next;

    t_div_stat                div_stat;
    logic [OUT_W-1:0]         div_q;
    logic                     out_free;

    // window length: zero counts as one, clamp at the ring size
    always_comb begin
        wl_ext = CMP_W'(r_window_len);
        if (wl_ext == '0) begin
            eff_m = MW'(1);
        end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
            eff_m = MW'(WINDOW_MAX);
        end else begin
            eff_m = MW'(wl_ext);
        end
    end

    // slot of the sample that leaves the window, m places behind the write pointer
    always_comb begin
        wp_x  = IDX_W'(r_wp);
        m_x   = IDX_W'(eff_m);
        old_x = (wp_x >= m_x) ? (wp_x - m_x) : (wp_x + IDX_W'(WINDOW_MAX) - m_x);
    end
    assign old_idx = old_x[PTR_W-1:0];

    assign wp_next     = (r_wp == PTR_W'(WINDOW_MAX - 1)) ? '0 : (r_wp + PTR_W'(1));
    assign window_full = (r_fill >= eff_m);
    assign fill_next   = window_full ? r_fill : (r_fill + MW'(1));

    // drop the leaving sample once the window is full, then add the new one
    assign old_term = window_full ? SUM_W'(signed'(ram_rd_data)) : '0;
    assign sum_next = r_sum - old_term + SUM_W'(r_sample);

    assign out_free = !r_out_valid || i_ready;

    swm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_UPD),
        .i_wr_addr (r_wp),
        .i_wr_data (r_sample),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (old_idx),
        .o_rd_data (ram_rd_data)
    );

    swm_div #(
        .SUM_W     (SUM_W),
        .DIV_W     (MW),
        .FRAC_BITS (FRAC_BITS),
        .OUT_W     (OUT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_sum      (r_sum),
        .i_divisor  (eff_m),
        .o_stat     (div_stat),
        .o_quotient (div_q)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_window_len <= WINDOW_LEN_RESET;
            r_fill       <= '0;
            r_wp         <= '0;
            r_sum        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // output register: loaded from the divider, emptied by its transfer
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cfg_wr_en) begin
                        r_window_len <= i_cfg_wr_data;
                        r_fill       <= '0;
                        r_wp         <= '0;
                        r_sum        <= '0;
                    end else if (i_valid) begin
                        // a new array empties the window before its first sample
                        if (i_new_array) begin
                            r_fill <= '0;
                            r_wp   <= '0;
                            r_sum  <= '0;
                        end
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_sum  <= sum_next;
                    r_fill <= fill_next;
                    r_wp   <= wp_next;
                    r_state <= (fill_next >= eff_m) ? S_START : S_IDLE;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_valid && !i_cfg_wr_en) begin
            r_sample <= i_sample;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_mean <= div_q;
        end
    end

    // a configuration write takes the cycle, the sample waits while i_cfg_wr_en is high
    assign o_ready       = (r_state == S_IDLE) && !i_cfg_wr_en;
    assign o_valid       = r_out_valid;
    assign o_window_mean = signed'(r_mean);

    // checks
    a_idle_div_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while sequencer idle");

    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= eff_m)
        else $error("fill count above window length");

    a_done_in_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    a_start_after_upd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START) |-> (r_fill >= eff_m))
        else $error("division started on a window that is not full");

endmodule

`default_nettype wire
